FILE: rtl/sbpa_pkg.sv
// Package for the sized buffer pool allocator.
// Holds port widths, request and status codes, the controller states and the
// control and flag structs passed between the controller and the slot cells.
package sbpa_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 64;
  localparam int unsigned CAP_WIDTH_DEF = 16;

  localparam int unsigned REQ_TYPE_W  = 2;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned HANDLE_W    = 6;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_NOP     = 2'd3
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_POOL_FULL = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INIT_COUNT = 2'd0,
    CFG_INIT_CAP   = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_FILL,
    FSM_EVAL,
    FSM_COMMIT
  } fsm_state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_EVAL,
    CELL_FILL,
    CELL_GRANT,
    CELL_INSERT,
    CELL_RELEASE
  } cell_op_e;

  // Command to one cell: the broadcast operation and the cell's own grant select.
  typedef struct packed {
    cell_op_e op;
    logic     sel;
  } cell_ctl_t;

  // Flags one cell reports: its busy mark and the predicates latched in evaluation.
  typedef struct packed {
    logic busy;
    logic fit;
    logic gt;
    logic hit;
  } cell_flags_t;

endpackage

FILE: rtl/sized_buffer_pool_allocator.sv
// Top level of the sized buffer pool allocator: controller, counters and the
// chain of slot cells. Depends on sbpa_pkg and sbpa_cell.
//
// Usage: requests enter on the input channel (req_type, request_size,
// slot_handle) with valid and stall; a transfer happens at an edge where
// in_valid_i is high and in_stall_o is low. Every request yields exactly one
// result on the output channel, held in an output register until a transfer
// with out_stall_i low takes it.
// The EVAL state latches each cell's compare results against the request, and
// the COMMIT state resolves the first fitting cell and updates the chain. A new
// request is taken in the COMMIT state, as the result of the last one is
// registered, while the output is drained.
// When the receiver stalls with a result waiting, the request in flight holds
// in the COMMIT state and no new request is taken.
// Configuration writes are taken only while no request is in flight. A write
// to either register refills the chain in the following cycle, during which
// no request is taken. At reset the pool is empty and both registers are zero.
module sized_buffer_pool_allocator #(
  parameter int unsigned MAX_SLOTS = sbpa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned CAP_WIDTH = sbpa_pkg::CAP_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sbpa_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [sbpa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sbpa_pkg::REQ_TYPE_W-1:0]  req_type_i,
  input  logic [sbpa_pkg::SIZE_W-1:0]      request_size_i,
  input  logic [sbpa_pkg::HANDLE_W-1:0]    slot_handle_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sbpa_pkg::STATUS_W-1:0]    status_o,
  output logic [sbpa_pkg::HANDLE_W-1:0]    granted_handle_o,
  output logic [sbpa_pkg::SIZE_W-1:0]      granted_capacity_o,
  output logic                             newly_created_o,
  output logic                             is_acquirable_o,
  output logic [sbpa_pkg::COUNT_W-1:0]     pool_size_o,
  output logic [sbpa_pkg::COUNT_W-1:0]     free_count_o
);
  import sbpa_pkg::*;

  localparam int unsigned ID_W  = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SAT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // State and configuration.
  fsm_state_e            state_q, state_d;
  logic [COUNT_W-1:0]    init_count_q;
  logic [SIZE_W-1:0]     base_cap_q;

  // Latched request.
  req_type_e             req_type_q;
  logic [CAP_WIDTH-1:0]  size_q;
  logic [HANDLE_W-1:0]   handle_q;

  // Pool counters.
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      free_q, free_d;

  // Result register.
  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [HANDLE_W-1:0]   ghandle_q, ghandle_d;
  logic [SIZE_W-1:0]     gcap_q, gcap_d;
  logic                  created_q, created_d;
  logic                  acq_q, acq_d;
  logic [CNT_W-1:0]      pool_q;
  logic [CNT_W-1:0]      avail_q;

  // Control.
  logic                  cfg_fire;
  logic                  cfg_refill;
  logic                  in_fire;
  logic                  can_emit;
  logic                  emit;
  cell_op_e              cell_op;

  // Width adapted views of fields.
  logic [CAP_WIDTH+SIZE_W-1:0]   size_ext;
  logic [CAP_WIDTH+SIZE_W-1:0]   req_size_ext;
  logic [CAP_WIDTH+SIZE_W-1:0]   fill_ext;
  logic [CAP_WIDTH-1:0]          fill_cap;
  logic [CNT_W-1:0]              fill_count;
  logic [CAP_WIDTH+SIZE_W-1:0]   gcap_ext;
  logic [ID_W+HANDLE_W-1:0]      gid_ext;
  logic [CNT_W+HANDLE_W-1:0]     new_handle_ext;
  logic [CNT_W+COUNT_W-1:0]      count_out_ext;
  logic [CNT_W+COUNT_W-1:0]      free_out_ext;

  // Chain wires.
  logic [CAP_WIDTH-1:0]  cell_cap   [MAX_SLOTS];
  logic [ID_W-1:0]       cell_id    [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  cell_valid;
  cell_flags_t           cell_flags [MAX_SLOTS];
  cell_ctl_t             cell_ctl   [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  fit_vec;
  logic [MAX_SLOTS-1:0]  hit_vec;
  logic [MAX_SLOTS-1:0]  busy_vec;
  logic [MAX_SLOTS-1:0]  first_fit;
  logic                  any_fit;
  logic                  any_hit;
  logic                  hit_busy;
  logic                  hit_free;
  logic [CAP_WIDTH-1:0]  sel_cap;
  logic [ID_W-1:0]       sel_id;

  assign size_ext     = (CAP_WIDTH + SIZE_W)'(request_size_i);
  assign req_size_ext = (CAP_WIDTH + SIZE_W)'(size_q);
  assign fill_ext     = (CAP_WIDTH + SIZE_W)'(base_cap_q);
  assign fill_cap     = fill_ext[CAP_WIDTH-1:0];
  assign fill_count   = (SAT_W'(init_count_q) > SAT_W'(MAX_SLOTS)) ?
                        CNT_W'(MAX_SLOTS) : CNT_W'(init_count_q);

  assign cfg_ready_o = (state_q == FSM_IDLE);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_refill  = cfg_fire && ((cfg_index_i == CFG_INIT_COUNT) ||
                                    (cfg_index_i == CFG_INIT_CAP));

  assign can_emit   = !out_valid_q || !out_stall_i;
  assign emit       = (state_q == FSM_COMMIT) && can_emit;
  assign in_stall_o = !((state_q == FSM_IDLE && !cfg_valid_i) || emit);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Flag vectors and the first free fitting cell (lowest set bit of fit_vec).
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      fit_vec[i]  = cell_flags[i].fit;
      hit_vec[i]  = cell_flags[i].hit;
      busy_vec[i] = cell_flags[i].busy;
    end
  end

  assign first_fit = fit_vec & (~fit_vec + MAX_SLOTS'(1));
  assign any_fit   = |fit_vec;
  assign any_hit   = |hit_vec;
  assign hit_busy  = |(hit_vec & busy_vec);
  assign hit_free  = |(hit_vec & ~busy_vec);

  always_comb begin
    sel_cap = '0;
    sel_id  = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (first_fit[i]) begin
        sel_cap = sel_cap | cell_cap[i];
        sel_id  = sel_id | cell_id[i];
      end
    end
  end

  assign gcap_ext       = (CAP_WIDTH + SIZE_W)'(sel_cap);
  assign gid_ext        = (ID_W + HANDLE_W)'(sel_id);
  assign new_handle_ext = (CNT_W + HANDLE_W)'(count_q);

  // Next state, cell command and result of the request in its commit cycle.
  always_comb begin
    state_d   = state_q;
    cell_op   = CELL_HOLD;
    count_d   = count_q;
    free_d    = free_q;
    status_d  = ST_OK;
    ghandle_d = '0;
    gcap_d    = '0;
    created_d = 1'b0;
    acq_d     = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        if (cfg_refill) begin
          state_d = FSM_FILL;
        end else if (in_fire) begin
          state_d = FSM_EVAL;
        end
      end
      FSM_FILL: begin
        cell_op = CELL_FILL;
        count_d = fill_count;
        free_d  = fill_count;
        state_d = FSM_IDLE;
      end
      FSM_EVAL: begin
        cell_op = CELL_EVAL;
        state_d = FSM_COMMIT;
      end
      FSM_COMMIT: begin
        if (can_emit) begin
          state_d = in_fire ? FSM_EVAL : FSM_IDLE;
          unique case (req_type_q)
            REQ_ACQUIRE: begin
              if (size_q == '0) begin
                status_d = ST_ZERO_SIZE;
              end else if (any_fit) begin
                cell_op   = CELL_GRANT;
                free_d    = free_q - CNT_W'(1);
                ghandle_d = gid_ext[HANDLE_W-1:0];
                gcap_d    = gcap_ext[SIZE_W-1:0];
              end else if (count_q == CNT_W'(MAX_SLOTS)) begin
                status_d = ST_POOL_FULL;
              end else begin
                cell_op   = CELL_INSERT;
                count_d   = count_q + CNT_W'(1);
                ghandle_d = new_handle_ext[HANDLE_W-1:0];
                gcap_d    = req_size_ext[SIZE_W-1:0];
                created_d = 1'b1;
              end
            end
            REQ_RELEASE: begin
              cell_op = CELL_RELEASE;
              if (!any_hit) begin
                status_d = ST_UNKNOWN;
              end else if (hit_busy) begin
                free_d = free_q + CNT_W'(1);
              end
            end
            REQ_QUERY: begin
              acq_d = hit_free;
            end
            REQ_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      init_count_q <= '0;
      base_cap_q   <= '0;
      count_q      <= '0;
      free_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      free_q  <= free_d;
      if (cfg_fire) begin
        if (cfg_index_i == CFG_INIT_COUNT) begin
          init_count_q <= cfg_data_i[COUNT_W-1:0];
        end else if (cfg_index_i == CFG_INIT_CAP) begin
          base_cap_q <= cfg_data_i;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The pool counts travel with the result so a refill cannot alter a waiting transfer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_type_q <= req_type_e'(req_type_i);
      size_q     <= size_ext[CAP_WIDTH-1:0];
      handle_q   <= slot_handle_i;
    end
    if (emit) begin
      status_q  <= status_d;
      ghandle_q <= ghandle_d;
      gcap_q    <= gcap_d;
      created_q <= created_d;
      acq_q     <= acq_d;
      pool_q    <= count_d;
      avail_q   <= free_d;
    end
  end

  // Chain of cells; cell 0 sees a valid, never greater left boundary.
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    logic [CAP_WIDTH-1:0] prev_cap;
    logic [ID_W-1:0]      prev_id;
    logic                 prev_busy;
    logic                 prev_gt;
    logic                 prev_valid;

    if (g == 0) begin : g_head
      assign prev_cap   = '0;
      assign prev_id    = '0;
      assign prev_busy  = 1'b0;
      assign prev_gt    = 1'b0;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_cap   = cell_cap[g-1];
      assign prev_id    = cell_id[g-1];
      assign prev_busy  = cell_flags[g-1].busy;
      assign prev_gt    = cell_flags[g-1].gt;
      assign prev_valid = cell_valid[g-1];
    end

    assign cell_ctl[g] = '{op: cell_op, sel: first_fit[g]};

    sbpa_cell #(
      .INDEX     (g),
      .CAP_WIDTH (CAP_WIDTH),
      .ID_W      (ID_W),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl[g]),
      .count_i      (count_q),
      .size_i       (size_q),
      .handle_i     (handle_q),
      .fill_cap_i   (fill_cap),
      .new_id_i     (count_q[ID_W-1:0]),
      .prev_cap_i   (prev_cap),
      .prev_id_i    (prev_id),
      .prev_busy_i  (prev_busy),
      .prev_gt_i    (prev_gt),
      .prev_valid_i (prev_valid),
      .cap_o        (cell_cap[g]),
      .id_o         (cell_id[g]),
      .valid_o      (cell_valid[g]),
      .flags_o      (cell_flags[g])
    );
  end

  assign count_out_ext = (CNT_W + COUNT_W)'(pool_q);
  assign free_out_ext  = (CNT_W + COUNT_W)'(avail_q);

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign granted_handle_o   = ghandle_q;
  assign granted_capacity_o = gcap_q;
  assign newly_created_o    = created_q;
  assign is_acquirable_o    = acq_q;
  assign pool_size_o        = count_out_ext[COUNT_W-1:0];
  assign free_count_o       = free_out_ext[COUNT_W-1:0];

endmodule

FILE: rtl/sbpa_cell.sv
// One slot cell of the sized buffer pool allocator chain.
// Holds a capacity, a handle and a busy mark, and shifts from its left neighbor
// on insert. Depends on sbpa_pkg.
module sbpa_cell #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned CAP_WIDTH = sbpa_pkg::CAP_WIDTH_DEF,
  parameter int unsigned ID_W      = 6,
  parameter int unsigned CNT_W     = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sbpa_pkg::cell_ctl_t          ctl_i,
  input  logic [CNT_W-1:0]             count_i,
  input  logic [CAP_WIDTH-1:0]         size_i,
  input  logic [sbpa_pkg::HANDLE_W-1:0] handle_i,
  input  logic [CAP_WIDTH-1:0]         fill_cap_i,
  input  logic [ID_W-1:0]              new_id_i,
  input  logic [CAP_WIDTH-1:0]         prev_cap_i,
  input  logic [ID_W-1:0]              prev_id_i,
  input  logic                         prev_busy_i,
  input  logic                         prev_gt_i,
  input  logic                         prev_valid_i,
  output logic [CAP_WIDTH-1:0]         cap_o,
  output logic [ID_W-1:0]              id_o,
  output logic                         valid_o,
  output sbpa_pkg::cell_flags_t        flags_o
);
  import sbpa_pkg::*;

  localparam int unsigned CMP_W = (ID_W > HANDLE_W) ? ID_W : HANDLE_W;

  logic [CAP_WIDTH-1:0] cap_q, cap_d;
  logic [ID_W-1:0]      id_q, id_d;
  logic                 busy_q, busy_d;
  logic                 fit_q, fit_d;
  logic                 gt_q, gt_d;
  logic                 hit_q, hit_d;
  logic                 valid;
  logic                 insert_here;

  assign valid = CNT_W'(INDEX) < count_i;

  // The table is sorted, so the cells greater than the request form a run that
  // reaches the end of the valid slots; the new slot goes where that run starts.
  assign insert_here = !prev_gt_i && (gt_q || (!valid && prev_valid_i));

  always_comb begin
    cap_d  = cap_q;
    id_d   = id_q;
    busy_d = busy_q;
    fit_d  = fit_q;
    gt_d   = gt_q;
    hit_d  = hit_q;
    unique case (ctl_i.op)
      CELL_HOLD: begin
      end
      CELL_EVAL: begin
        fit_d = valid && !busy_q && (cap_q >= size_i);
        gt_d  = valid && (cap_q > size_i);
        hit_d = valid && (CMP_W'(id_q) == CMP_W'(handle_i));
      end
      CELL_FILL: begin
        cap_d  = fill_cap_i;
        id_d   = ID_W'(INDEX);
        busy_d = 1'b0;
      end
      CELL_GRANT: begin
        if (ctl_i.sel) begin
          busy_d = 1'b1;
        end
      end
      CELL_INSERT: begin
        if (prev_gt_i) begin
          cap_d  = prev_cap_i;
          id_d   = prev_id_i;
          busy_d = prev_busy_i;
        end else if (insert_here) begin
          cap_d  = size_i;
          id_d   = new_id_i;
          busy_d = 1'b1;
        end
      end
      CELL_RELEASE: begin
        if (hit_q) begin
          busy_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
    id_q  <= id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fit_q  <= 1'b0;
      gt_q   <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fit_q  <= fit_d;
      gt_q   <= gt_d;
      hit_q  <= hit_d;
    end
  end

  assign cap_o   = cap_q;
  assign id_o    = id_q;
  assign valid_o = valid;
  assign flags_o = '{busy: busy_q, fit: fit_q, gt: gt_q, hit: hit_q};

endmodule
